[sv/slcanlr_pkg.sv]
// ----------------------------------------------------------------------------
// slcanlr_pkg: shared types and constants of the slcan line receiver
// Character codes, frame layout and the hex digit decoder used by the parser,
// the output register and the top level.
// ----------------------------------------------------------------------------
package slcanlr_pkg;

  // Default length of the line buffer, counted in characters.
  localparam int LINE_STORE_DEF = 64;

  // Character codes.
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_LF      = 8'h0A;
  localparam logic [7:0] CHAR_STD     = 8'h74;  // 't'
  localparam logic [7:0] CHAR_EXT     = 8'h54;  // 'T'

  // Line layout.
  localparam int ID_LEN_STD = 3;
  localparam int ID_LEN_EXT = 8;
  localparam int MAX_DLC    = 8;
  localparam int MIN_LINE   = 5;

  // Port widths.
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 104;  // 32 + 4 + 64 bits, padded to whole bytes

  typedef struct packed {
    logic [63:0] payload;
    logic [3:0]  dlc;
    logic        extended;
    logic [31:0] frame_id;
  } frame_t;

  // Hex digit decoder: bit 4 is set when the character is not a hex digit.
  typedef struct packed {
    logic       bad;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.bad   = 1'b0;
    h.value = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      h.value = c[3:0];
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      h.value = c[3:0] + 4'd9;
    end else begin
      h.bad = 1'b1;
    end
    return h;
  endfunction

endpackage

[sv/slcanlr_parser.sv]
// ----------------------------------------------------------------------------
// slcanlr_parser: incremental slcan line parser
// Keeps the state of the line in progress and folds in one character per
// enabled cycle; flags a finished frame when a well-formed line terminates.
// ----------------------------------------------------------------------------
module slcanlr_parser #(
  parameter int LINE_STORE = slcanlr_pkg::LINE_STORE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  logic [7:0]           rx_byte,
  output logic                 frame_valid,
  output slcanlr_pkg::frame_t  frame
);
  import slcanlr_pkg::*;

  localparam int CW = $clog2(LINE_STORE);

  logic [CW-1:0] count_r, count_nxt;
  logic          kind_r, kind_nxt;
  logic [31:0]   id_r, id_nxt;
  logic [3:0]    dlc_r, dlc_nxt;
  logic [63:0]   pay_r, pay_nxt;
  logic          bad_r, bad_nxt;

  logic [CW-1:0] idlen;
  logic [CW-1:0] data_idx;
  logic [CW-1:0] two_dlc;
  logic [CW:0]   need_len;
  logic [5:0]    nib_shift;
  logic          is_term;
  logic          line_ok;
  hex_t          hex;

  assign idlen    = kind_r ? CW'(ID_LEN_EXT) : CW'(ID_LEN_STD);
  assign data_idx = count_r - idlen - CW'(2);
  assign two_dlc  = CW'({dlc_r, 1'b0});
  assign need_len = (CW+1)'(idlen) + (CW+1)'(2) + (CW+1)'({dlc_r, 1'b0});
  // Even data digits are high nibbles.
  assign nib_shift = {data_idx[3:1], ~data_idx[0], 2'b00};
  assign is_term  = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);
  assign hex      = hex_decode(rx_byte);

  assign line_ok = !bad_r && ({1'b0, count_r} >= (CW+1)'(MIN_LINE))
                   && ({1'b0, count_r} >= need_len);

  assign frame_valid    = take && is_term && (count_r != '0) && line_ok;
  assign frame.frame_id = id_r;
  assign frame.extended = kind_r;
  assign frame.dlc      = dlc_r;
  assign frame.payload  = pay_r;

  always_comb begin
    count_nxt = count_r;
    kind_nxt  = kind_r;
    id_nxt    = id_r;
    dlc_nxt   = dlc_r;
    pay_nxt   = pay_r;
    bad_nxt   = bad_r;
    if (take) begin
      if (is_term || (count_r >= CW'(LINE_STORE - 1))) begin
        // A terminator closes the line; an overlong line starts over and
        // drops the character. An empty line leaves everything cleared.
        count_nxt = '0;
        kind_nxt  = 1'b0;
        id_nxt    = '0;
        dlc_nxt   = '0;
        pay_nxt   = '0;
        bad_nxt   = 1'b0;
      end else begin
        count_nxt = count_r + CW'(1);
        if (count_r == '0) begin
          kind_nxt = (rx_byte == CHAR_EXT);
          bad_nxt  = (rx_byte != CHAR_EXT) && (rx_byte != CHAR_STD);
        end else if (!bad_r) begin
          if (count_r <= idlen) begin
            if (hex.bad) begin
              bad_nxt = 1'b1;
            end else begin
              id_nxt = {id_r[27:0], hex.value};
            end
          end else if (count_r == idlen + CW'(1)) begin
            if (hex.bad) begin
              bad_nxt = 1'b1;
            end else begin
              dlc_nxt = (hex.value > 4'(MAX_DLC)) ? 4'(MAX_DLC) : hex.value;
            end
          end else if (data_idx < two_dlc) begin
            // Characters past the last data digit are ignored.
            if (hex.bad) begin
              bad_nxt = 1'b1;
            end else begin
              pay_nxt = pay_r | (64'(hex.value) << nib_shift);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      kind_r  <= 1'b0;
      id_r    <= '0;
      dlc_r   <= '0;
      pay_r   <= '0;
      bad_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      kind_r  <= kind_nxt;
      id_r    <= id_nxt;
      dlc_r   <= dlc_nxt;
      pay_r   <= pay_nxt;
      bad_r   <= bad_nxt;
    end
  end

  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    take && is_term |=> count_r == '0)
    else $error("line count not cleared after terminator");

  a_dlc_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    dlc_r <= 4'(MAX_DLC))
    else $error("dlc above clamp");

  a_std_id_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    frame_valid && !kind_r |-> id_r[31:12] == '0)
    else $error("standard identifier wider than 12 bits");

endmodule

[sv/slcanlr_out_reg.sv]
// ----------------------------------------------------------------------------
// slcanlr_out_reg: result register of the slcan line receiver
// Holds one finished frame until the downstream side takes it.
// ----------------------------------------------------------------------------
module slcanlr_out_reg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 load,
  input  slcanlr_pkg::frame_t                  frame,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [slcanlr_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                                 out_tuser
);
  import slcanlr_pkg::*;

  logic   valid_r, valid_nxt;
  frame_t frame_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_r <= frame;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {4'b0000, frame_r.payload, frame_r.dlc, frame_r.frame_id};
  assign out_tuser  = frame_r.extended;

endmodule

[sv/slcan_line_receiver_unit.sv]
// ----------------------------------------------------------------------------
// slcan_line_receiver_unit: slcan text line to CAN frame receiver
// Parses received slcan characters and emits one CAN frame per valid line.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one received character per word in in_tdata.
//   Lines end with CR or LF. A line starting with 't' (3 identifier digits)
//   or 'T' (8 identifier digits), followed by a DLC digit (9..F count as 8)
//   and two hex digits per data byte, yields one word on the output stream
//   when its terminator arrives. Malformed and empty lines give nothing, and
//   a line reaching LINE_STORE characters starts over, dropping that
//   character.
//   A terminator accepted on the input is held in the input register; the
//   parser then loads its frame into the output register as soon as that
//   register is free or being emptied, and the frame is offered from there.
//   Throughput: one character per cycle; the parser updates its line state
//   per taken character, so nothing limits the rate but the output handshake.
//   When the output word is not taken, the input register still takes one
//   more character; after that in_tready drops until the frame leaves.
//   Reset (rst_n low, synchronous) empties both registers and clears the
//   line in progress.
// ----------------------------------------------------------------------------
module slcan_line_receiver_unit #(
  parameter int LINE_STORE = slcanlr_pkg::LINE_STORE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Character input.
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [slcanlr_pkg::IN_TDATA_W-1:0]   in_tdata,   // [7:0] rx_byte
  // Frame output.
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [31:0] frame_id, [35:32] dlc, [99:36] payload, [103:100] zero
  output logic [slcanlr_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                                 out_tuser   // [0] extended
);
  import slcanlr_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       take;
  logic       frame_valid;
  frame_t     frame;

  // The parser consumes the held character whenever the output register
  // can absorb a frame this cycle, so no terminator is ever lost.
  assign take      = s1_valid_r && (!out_tvalid || out_tready);
  assign in_tready = !s1_valid_r || take;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tvalid && in_tready) begin
      s1_valid_nxt = 1'b1;
    end else if (take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
    end
  end

  slcanlr_parser #(
    .LINE_STORE (LINE_STORE)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .rx_byte     (s1_byte_r),
    .frame_valid (frame_valid),
    .frame       (frame)
  );

  slcanlr_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (frame_valid),
    .frame      (frame),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && out_tvalid && !out_tready)
    else $error("input stalled without a blocked output");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    frame_valid |-> !out_tvalid || out_tready)
    else $error("frame loaded over a pending result");

  a_out_dlc: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[35:32] <= 4'(MAX_DLC) && out_tdata[103:100] == 4'b0000)
    else $error("output word malformed");

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: character-stream check of the slcan line receiver
// Feeds slcan text lines one character per word. A table of hand-made lines
// covers the corner cases first. Random lines follow: mostly well-formed,
// some corrupted, cut short, overlong or pure noise. Every frame is compared
// field by field with its table row or an independent line parser, while
// both stream sides idle and stall in random bursts.
// ----------------------------------------------------------------------------
module testbench;
  import slcanlr_pkg::*;

  localparam int RANDOM_CHARS = 1000;
  localparam int CALM_CHARS   = 850;   // no idling on either side after this many

  // A line of the directed table: head, then a run of filler characters, then
  // tail. For lines whose outcome is plain, the expected frame is written in
  // the row itself; otherwise the parser below supplies it.
  typedef struct {
    string       head;
    int          fill;
    string       tail;
    bit          known;
    bit          want;
    logic [31:0] frame_id;
    logic        extended;
    logic [3:0]  dlc;
    logic [63:0] payload;
  } line_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [7:0] rx_byte
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [31:0] id, [35:32] dlc, [99:36] payload
  logic                   out_tuser;       // [0] extended

  // Parser state of the line in progress, kept independently of the block.
  int          line_len;
  logic        ext_line;
  logic [31:0] id_acc;
  logic [3:0]  dlc_seen;
  logic [63:0] data_acc;
  logic        line_failed;

  frame_t      frames_due[$];
  line_row_t   rows[$];
  int          errors = 0;
  int          chars_sent = 0;
  int          lines_sent = 0;
  int          frames_seen = 0;
  bit          quiet = 1'b0;       // set for the final stretch: no idling at all
  bit          gaps_on = 1'b1;
  int          stall_left = 0;

  slcan_line_receiver_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Case-insensitive hex digit; returns 0 for anything else.
  function automatic bit hex_val(input logic [7:0] c, output logic [3:0] v);
    v = 4'd0;
    if (c >= "0" && c <= "9") begin
      v = 4'(c - "0");
      return 1'b1;
    end
    if (c >= "a" && c <= "f") begin
      v = 4'(c - "a" + 10);
      return 1'b1;
    end
    if (c >= "A" && c <= "F") begin
      v = 4'(c - "A" + 10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void clear_line();
    line_len    = 0;
    ext_line    = 1'b0;
    id_acc      = '0;
    dlc_seen    = '0;
    data_acc    = '0;
    line_failed = 1'b0;
  endfunction

  // Advances the line parser by one character. Returns 1 with the frame when
  // the character terminates a well-formed line.
  function automatic bit parse_char(input logic [7:0] c, output frame_t fr);
    int         idlen;
    int         pos;
    int         j;
    logic [3:0] v;
    bit         ok;
    fr    = '0;
    idlen = ext_line ? ID_LEN_EXT : ID_LEN_STD;
    if (c == CHAR_CR || c == CHAR_LF) begin
      // Empty lines fall straight through; anything else ends the line.
      if (line_len == 0) return 1'b0;
      ok = !line_failed && line_len >= MIN_LINE && line_len >= idlen + 2 &&
           line_len >= idlen + 2 + 2 * int'(dlc_seen);
      fr.frame_id = id_acc;
      fr.extended = ext_line;
      fr.dlc      = dlc_seen;
      fr.payload  = data_acc;
      clear_line();
      return ok;
    end
    // The character that would fill the line store is dropped and the line
    // starts over from nothing.
    if (line_len + 1 >= LINE_STORE_DEF) begin
      clear_line();
      return 1'b0;
    end
    pos = line_len;
    line_len++;
    if (pos == 0) begin
      if (c == CHAR_STD) ext_line = 1'b0;
      else if (c == CHAR_EXT) ext_line = 1'b1;
      else line_failed = 1'b1;
      return 1'b0;
    end
    if (line_failed) return 1'b0;
    if (pos <= idlen) begin
      if (!hex_val(c, v)) line_failed = 1'b1;
      else id_acc = {id_acc[27:0], v};
    end else if (pos == idlen + 1) begin
      if (!hex_val(c, v)) line_failed = 1'b1;
      else dlc_seen = (v > MAX_DLC) ? 4'(MAX_DLC) : v;
    end else begin
      // Data nibbles, high nibble of each byte first; characters past the
      // last required digit are ignored.
      j = pos - (idlen + 2);
      if (j < 2 * int'(dlc_seen)) begin
        if (!hex_val(c, v)) line_failed = 1'b1;
        else data_acc |= 64'(v) << (8 * (j >> 1) + ((j & 1) ? 0 : 4));
      end
    end
    return 1'b0;
  endfunction

  // Sends one character and, once it is taken, runs it through the parser.
  // When track is set, a frame that the character completes is expected.
  task automatic send_char(input logic [7:0] c, input bit track);
    frame_t fr;
    if (!quiet && gaps_on && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    do @(posedge clk); while (!in_tready);
    chars_sent++;
    if (parse_char(c, fr) && track) frames_due.push_back(fr);
  endtask

  task automatic add_line(input string head, input int fill, input string tail);
    line_row_t r;
    r.head  = head;
    r.fill  = fill;
    r.tail  = tail;
    r.known = 1'b0;
    r.want  = 1'b0;
    r.frame_id = '0;
    r.extended = 1'b0;
    r.dlc      = '0;
    r.payload  = '0;
    rows.push_back(r);
  endtask

  task automatic add_known(input string text, input bit want, input logic [31:0] id,
                           input logic ext, input logic [3:0] dlc,
                           input logic [63:0] payload);
    line_row_t r;
    r.head     = text;
    r.fill     = 0;
    r.tail     = "";
    r.known    = 1'b1;
    r.want     = want;
    r.frame_id = id;
    r.extended = ext;
    r.dlc      = dlc;
    r.payload  = payload;
    rows.push_back(r);
  endtask

  // One hex digit in a random letter case.
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 10) return 8'("0" + v);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CHAR_CR || c == CHAR_LF);
    return c;
  endfunction

  // Builds a well-formed line with random content, terminator not included.
  task automatic build_good(ref logic [7:0] q[$]);
    logic [3:0] dlc_digit;
    int         n_id;
    int         n_data;
    bit         ext;
    ext       = $urandom_range(0, 1);
    n_id      = ext ? ID_LEN_EXT : ID_LEN_STD;
    dlc_digit = 4'($urandom_range(0, 15));
    n_data    = 2 * ((dlc_digit > MAX_DLC) ? MAX_DLC : int'(dlc_digit));
    q.push_back(ext ? CHAR_EXT : CHAR_STD);
    repeat (n_id) q.push_back(hex_char(4'($urandom_range(0, 15))));
    q.push_back(hex_char(dlc_digit));
    repeat (n_data) q.push_back(hex_char(4'($urandom_range(0, 15))));
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) q.push_back(plain_char());
  endtask

  // Result side: random stall bursts, none during reset or the final stretch.
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 11) == 0) begin
      stall_left <= $urandom_range(0, 18);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Each frame taken from the block must match the oldest one expected.
  always @(posedge clk) begin
    frame_t want;
    if (rst_n && out_tvalid && out_tready) begin
      frames_seen++;
      if (frames_due.size() == 0) begin
        $error("frame with id %h arrived with none expected", out_tdata[31:0]);
        errors++;
      end else begin
        want = frames_due.pop_front();
        if (out_tdata[31:0] !== want.frame_id) begin
          $error("frame_id: expected %h, got %h", want.frame_id, out_tdata[31:0]);
          errors++;
        end
        if (out_tuser !== want.extended) begin
          $error("extended: expected %b, got %b", want.extended, out_tuser);
          errors++;
        end
        if (out_tdata[35:32] !== want.dlc) begin
          $error("dlc: expected %0d, got %0d", want.dlc, out_tdata[35:32]);
          errors++;
        end
        if (out_tdata[99:36] !== want.payload) begin
          $error("payload: expected %h, got %h", want.payload, out_tdata[99:36]);
          errors++;
        end
        if (out_tdata[103:100] !== 4'd0) begin
          $error("padding: expected 0, got %h", out_tdata[103:100]);
          errors++;
        end
      end
    end
  end

  initial begin
    logic [7:0] line_q[$];
    int         pick;
    int         cut;
    int         random_start;
    clear_line();

    // Empty lines, extremes, malformed lines and the line-store boundary.
    add_known("\r", 1'b0, '0, 1'b0, '0, '0);
    add_known("\n", 1'b0, '0, 1'b0, '0, '0);
    add_known("t0000\r", 1'b1, 32'h0, 1'b0, 4'd0, 64'h0);
    add_known("TFFFFFFFF8FFFFFFFFFFFFFFFF\n", 1'b1, 32'hFFFF_FFFF, 1'b1, 4'd8,
              64'hFFFF_FFFF_FFFF_FFFF);
    add_line("t7FF2a5B3\r", 0, "");
    add_line("t123F0011223344556677\n", 0, "");
    add_line("T123456789deadBEEF0badF00d\r", 0, "");
    add_line("t0ab1cD\n", 0, "");
    add_line("t1231ABjunk!\r", 0, "");
    add_known("T1aBcDeF03\r", 1'b0, '0, 1'b1, '0, '0);   // ends before its data
    add_known("t12\r", 1'b0, '0, 1'b0, '0, '0);          // ends inside the id
    add_known("t123\r", 1'b0, '0, 1'b0, '0, '0);         // no DLC digit
    add_known("x1230\r", 1'b0, '0, 1'b0, '0, '0);        // wrong first character
    add_known("t1g30\r", 1'b0, '0, 1'b0, '0, '0);        // bad identifier digit
    add_known("t123G\r", 1'b0, '0, 1'b0, '0, '0);        // bad DLC digit
    add_known("t1231z0\r", 1'b0, '0, 1'b0, '0, '0);      // bad data digit
    add_line("", 64, "t3211C3\r");                       // overflow, then a fresh line
    add_line("t5A50", 58, "\r");                         // longest line that fits
    add_known("t5A50~~~~~~~~~~~~~~~~~~~~~~~~~~~~~~~~~~~~~~~~~~~~~~~~~~~~~~~~~~~~~~\r",
              1'b0, '0, 1'b0, '0, '0);                   // one character too many

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      line_q.delete();
      for (int k = 0; k < rows[i].head.len(); k++) line_q.push_back(rows[i].head[k]);
      repeat (rows[i].fill) line_q.push_back("~");
      for (int k = 0; k < rows[i].tail.len(); k++) line_q.push_back(rows[i].tail[k]);
      foreach (line_q[k]) send_char(line_q[k], !rows[i].known);
      if (rows[i].known && rows[i].want)
        frames_due.push_back('{payload: rows[i].payload, dlc: rows[i].dlc,
                               extended: rows[i].extended, frame_id: rows[i].frame_id});
      lines_sent++;
    end

    // Random lines: mostly well-formed, the rest broken in various ways.
    random_start = chars_sent;
    while (chars_sent - random_start < RANDOM_CHARS) begin
      line_q.delete();
      pick    = $urandom_range(0, 99);
      gaps_on = ($urandom_range(0, 4) != 0);
      quiet   = (chars_sent - random_start >= CALM_CHARS);
      if (pick < 70) begin
        build_good(line_q);
      end else if (pick < 80) begin
        build_good(line_q);
        line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (pick < 88) begin
        build_good(line_q);
        cut = $urandom_range(1, line_q.size());
        while (line_q.size() > cut) void'(line_q.pop_back());
      end else if (pick < 94) begin
        repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 97) begin
        // terminator only
      end else begin
        repeat ($urandom_range(60, 70)) line_q.push_back(plain_char());
        build_good(line_q);
      end
      line_q.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
      foreach (line_q[k]) send_char(line_q[k], 1'b1);
      lines_sent++;
    end
    in_tvalid <= 1'b0;

    // Let every expected frame drain, then keep watching for anything the block
    // should not have produced.
    while (frames_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d characters in %0d lines (directed table plus random lines).",
             chars_sent, lines_sent);
    $display("Compared %0d frames against the line parser, %0d mismatches.",
             frames_seen, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

[slcan_line_receiver_unit.f]
sv/slcanlr_pkg.sv
sv/slcanlr_parser.sv
sv/slcanlr_out_reg.sv
sv/slcan_line_receiver_unit.sv
tb/testbench.sv
